// ===== hdl/pfp_pkg.sv =====
// shared constants, types and helpers for the parameter frame parser
// no dependencies
`default_nettype none

package pfp_pkg;

    // parameter table size and index width
    localparam int TABLE_SIZE = 32;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // frame constants
    localparam logic [7:0]  HDR0      = 8'h55;
    localparam logic [7:0]  HDR1      = 8'hAA;
    localparam logic [31:0] ONE_FLOAT = 32'h3F80_0000;
    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_ENTRY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_CMD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_ALL_CMD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_CMD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_GAIN_ID = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic capture;     // input word accepted
        logic latch;       // good frame end, latch id, word and flags
        logic wr_id;       // write data word to table at id
        logic wr_ack;      // write 1.0 to table at ack entry
        logic load_ack;    // load output word with ack frame
        logic rd_issue;    // read table at sweep index
        logic load_entry;  // load output word with table entry
    } pfp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic frame_ok;    // current accepted word closes a good frame
        logic read_all;    // latched frame is a read-all command
        logic last_sent;   // output word holds the last frame of the burst
    } pfp_status_t;

    // id plus the four bytes of a word, modulo 256
    function automatic logic [7:0] frame_sum(input logic [7:0] id, input logic [31:0] w);
        frame_sum = id + w[7:0] + w[15:8] + w[23:16] + w[31:24];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pfp_ctrl.sv =====
// controller state machine for the parameter frame parser
// depends on pfp_pkg
`default_nettype none

module pfp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire pfp_pkg::pfp_status_t status,
    output pfp_pkg::pfp_cmd_t        cmd
);
    import pfp_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WR_ID   = 3'd1;
    localparam logic [2:0] S_WR_ACK  = 3'd2;
    localparam logic [2:0] S_ACK_OUT = 3'd3;
    localparam logic [2:0] S_RD_REQ  = 3'd4;
    localparam logic [2:0] S_RD_LOAD = 3'd5;
    localparam logic [2:0] S_RD_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_taken;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_taken = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.frame_ok)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_WR_ID;
                    end
                end
            end
            S_WR_ID:
            begin
                cmd.wr_id  = 1'b1;
                state_next = S_WR_ACK;
            end
            S_WR_ACK:
            begin
                cmd.wr_ack     = 1'b1;
                cmd.load_ack   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_ACK_OUT;
            end
            S_ACK_OUT:
            begin
                if (out_taken)
                begin
                    out_valid_next = 1'b0;
                    state_next     = status.read_all ? S_RD_REQ : S_IDLE;
                end
            end
            S_RD_REQ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_LOAD;
            end
            S_RD_LOAD:
            begin
                cmd.load_entry = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (out_taken)
                begin
                    out_valid_next = 1'b0;
                    state_next     = status.last_sent ? S_IDLE : S_RD_REQ;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
                state_next     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfp_datapath.sv =====
// datapath of the parameter frame parser: byte capture, checks,
// configuration registers, parameter table and output word
// depends on pfp_pkg
`default_nettype none

module pfp_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [pfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [7:0]                          cfg_data,
    input  wire logic [7:0]                          rx_byte,
    input  wire logic                                frame_end,
    input  wire pfp_pkg::pfp_cmd_t                   cmd,
    output pfp_pkg::pfp_status_t                     status,
    output logic [7:0]                               tx_id,
    output logic [31:0]                              tx_value,
    output logic [7:0]                               tx_sum,
    output logic                                     reset_request,
    output logic                                     jump_request,
    output logic                                     gains_updated,
    output logic                                     last_frame
);
    import pfp_pkg::*;

    localparam logic [7:0]       TABLE_SIZE_B = 8'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX     = IDX_W'(TABLE_SIZE - 1);

    // configuration
    logic [7:0] ack_entry_reg, reset_cmd_reg, read_all_cmd_reg, jump_cmd_reg, last_gain_reg;

    // frame capture
    logic [3:0] pos_reg, pos_next;
    logic [7:0] cap_reg [8];
    logic [31:0] cap_word;
    logic        frame_ok;

    // latched frame
    logic [7:0]       id_reg;
    logic [31:0]      word_reg;
    logic             rst_req_reg, jmp_req_reg, gains_reg, read_all_reg;
    logic [IDX_W-1:0] idx_reg;

    // table
    logic [31:0]           mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] vld_reg;
    logic [31:0]           rd_data_reg;
    logic                  rd_vld_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_addr;
    logic [31:0]           mem_wdata;

    logic        id_in_table, ack_in_table, cmd_nonzero;
    logic        hit_reset, hit_read_all, hit_jump;
    logic [31:0] ack_value, entry_value;
    logic [7:0]  entry_id;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_entry_reg    <= 8'd31;
            reset_cmd_reg    <= 8'd30;
            read_all_cmd_reg <= 8'd29;
            jump_cmd_reg     <= 8'd28;
            last_gain_reg    <= 8'd17;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACK_ENTRY:    ack_entry_reg    <= cfg_data;
                CFG_RESET_CMD:    reset_cmd_reg    <= cfg_data;
                CFG_READ_ALL_CMD: read_all_cmd_reg <= cfg_data;
                CFG_JUMP_CMD:     jump_cmd_reg     <= cfg_data;
                CFG_LAST_GAIN_ID: last_gain_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // byte position saturates at nine, cleared by a frame end
    always_comb
    begin
        pos_next = pos_reg;
        if (frame_end)
            pos_next = 4'd0;
        else if (pos_reg < 4'd9)
            pos_next = pos_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 4'd0;
        else if (cmd.capture)
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && (pos_reg < 4'd8))
            cap_reg[pos_reg[2:0]] <= rx_byte;
    end

    assign cap_word = {cap_reg[6], cap_reg[5], cap_reg[4], cap_reg[3]};

    // ninth or later byte with frame end, header and sum good
    assign frame_ok = frame_end && (pos_reg >= 4'd8) &&
                      (cap_reg[0] == HDR0) && (cap_reg[1] == HDR1) &&
                      (frame_sum(cap_reg[2], cap_word) == cap_reg[7]);

    // command decode on the frame being latched; the table value at id after
    // the writes is 1.0 when id is the ack entry, else the new word
    assign id_in_table  = (id_reg < TABLE_SIZE_B);
    assign ack_in_table = (ack_entry_reg < TABLE_SIZE_B);
    assign cmd_nonzero  = (cap_reg[2] < TABLE_SIZE_B) &&
                          ((cap_reg[2] == ack_entry_reg) || ((cap_word & MAG_MASK) != 32'd0));
    assign hit_reset    = (cap_reg[2] == reset_cmd_reg);
    assign hit_read_all = !hit_reset && (cap_reg[2] == read_all_cmd_reg);
    assign hit_jump     = !hit_reset && !hit_read_all && (cap_reg[2] == jump_cmd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            id_reg      <= cap_reg[2];
            word_reg    <= cap_word;
            rst_req_reg <= hit_reset && cmd_nonzero;
            jmp_req_reg <= hit_jump && cmd_nonzero;
            gains_reg   <= (cap_reg[2] <= last_gain_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_all_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                read_all_reg <= hit_read_all;
                idx_reg      <= '0;
            end
            else if (cmd.load_entry)
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // table write port: id word first, ack entry second so it wins
    assign mem_we    = (cmd.wr_id && id_in_table) || (cmd.wr_ack && ack_in_table);
    assign mem_addr  = cmd.wr_ack ? ack_entry_reg[IDX_W-1:0] : id_reg[IDX_W-1:0];
    assign mem_wdata = cmd.wr_ack ? ONE_FLOAT : word_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.rd_issue)
            rd_data_reg <= mem[idx_reg];
    end

    // never-written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[mem_addr] <= 1'b1;
            if (cmd.rd_issue)
                rd_vld_reg <= vld_reg[idx_reg];
        end
    end

    assign ack_value   = ack_in_table ? ONE_FLOAT : 32'd0;
    assign entry_value = rd_vld_reg ? rd_data_reg : 32'd0;
    assign entry_id    = 8'(idx_reg);

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_ack)
        begin
            tx_id         <= ack_entry_reg;
            tx_value      <= ack_value;
            tx_sum        <= frame_sum(ack_entry_reg, ack_value);
            reset_request <= rst_req_reg;
            jump_request  <= jmp_req_reg;
            gains_updated <= gains_reg;
            last_frame    <= !read_all_reg;
        end
        else if (cmd.load_entry)
        begin
            tx_id         <= entry_id;
            tx_value      <= entry_value;
            tx_sum        <= frame_sum(entry_id, entry_value);
            reset_request <= 1'b0;
            jump_request  <= 1'b0;
            gains_updated <= 1'b0;
            last_frame    <= (idx_reg == LAST_IDX);
        end
    end

    assign status.frame_ok  = frame_ok;
    assign status.read_all  = read_all_reg;
    assign status.last_sent = last_frame;

endmodule

`default_nettype wire

// ===== hdl/param_frame_parser_with_ack.sv =====
// top level of the parameter frame parser with acknowledge
// instantiates pfp_ctrl and pfp_datapath, uses pfp_pkg
`default_nettype none

// Takes received serial bytes of a 9-byte parameter frame (0x55, 0xAA, id,
// four little-endian data bytes, sum, tail), one byte per input word, with
// frame_end marking the byte after which the line went idle. A frame ending
// with at least nine bytes, a good header and a good 8-bit sum writes its data
// word into the 32-entry parameter table (when id is in range), writes 1.0
// into the ack entry and sends one ack frame word carrying the command flags
// (reset_request, jump_request, gains_updated). A read-all command then sends
// every table entry in order, one output word each; last_frame marks the
// final output word of a frame. Short, bad-header or bad-sum frames give no
// output. Bytes are accepted back to back while the block is idle. The byte
// that closes a good frame holds the input off through the data word write,
// then the ack entry write together with the output register load (one write
// port), then for as long as the ack word is offered and not yet taken.
// Each read-all entry goes through read issue, output register load from the
// registered read data, then the word offered until taken, since the table
// has one registered read port. Input is stalled while a good frame is being
// handled. The table reads as all zeros after reset, through its valid bits,
// with no clearing pass. Configuration is to be written through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block itself
// does not enforce this.
module param_frame_parser_with_ack (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [pfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                      cfg_data,
    // received byte channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            frame_end,
    // outgoing frame channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [7:0]                           tx_id,
    output logic [31:0]                          tx_value,
    output logic [7:0]                           tx_sum,
    output logic                                 reset_request,
    output logic                                 jump_request,
    output logic                                 gains_updated,
    output logic                                 last_frame
);
    import pfp_pkg::*;

    // command and status between controller and datapath
    pfp_cmd_t    cmd;
    pfp_status_t status;

    // sequencing: byte capture, table writes, ack and read-all sweep
    pfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // capture, checks, table and output word registers
    pfp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .cmd           (cmd),
        .status        (status),
        .tx_id         (tx_id),
        .tx_value      (tx_value),
        .tx_sum        (tx_sum),
        .reset_request (reset_request),
        .jump_request  (jump_request),
        .gains_updated (gains_updated),
        .last_frame    (last_frame)
    );

endmodule

`default_nettype wire

// ===== sim/pfp_frame_checker.sv =====
// checker for the parameter frame parser: watches both word channels and the
// config port, predicts the outgoing frames and compares them; uses pfp_pkg
`timescale 1ns / 1ps

module pfp_frame_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    input  logic                          frame_end,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [7:0]                    tx_id,
    input  logic [31:0]                   tx_value,
    input  logic [7:0]                    tx_sum,
    input  logic                          reset_request,
    input  logic                          jump_request,
    input  logic                          gains_updated,
    input  logic                          last_frame,
    input  logic                          run_over,
    output int                            fail_count,
    output int                            due_count,
    output int                            frames_checked,
    output int                            bursts_seen
);

    import pfp_pkg::*;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] value;
        logic [7:0]  sum;
        logic        rst_req;
        logic        jmp_req;
        logic        gains;
        logic        last;
    } tx_frame_t;

    // register copies
    logic [7:0] ack_idx;
    logic [7:0] rst_id;
    logic [7:0] rdall_id;
    logic [7:0] jmp_id;
    logic [7:0] gain_limit;

    // parser state
    logic [3:0]  byte_pos;
    logic [7:0]  capture [0:7];
    logic [31:0] param_mem [0:TABLE_SIZE-1];

    tx_frame_t frames_due [$];
    int errors;
    int checked;
    int bursts;

    function automatic logic [7:0] byte_sum(input logic [7:0] id, input logic [31:0] w);
        return id + w[7:0] + w[15:8] + w[23:16] + w[31:24];
    endfunction

    // ids outside the table read as zero
    function automatic logic [31:0] entry_at(input logic [7:0] idx);
        return (idx < TABLE_SIZE) ? param_mem[idx[IDX_W-1:0]] : 32'h0;
    endfunction

    function automatic tx_frame_t make_frame(input logic [7:0] id, input logic [31:0] w);
        tx_frame_t f;
        f = '0;
        f.id = id;
        f.value = w;
        f.sum = byte_sum(id, w);
        return f;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // one received byte; queues the frames that it causes
    task automatic parse_rx_byte(input logic [7:0] b, input logic e);
        logic [7:0]  id;
        logic [31:0] word;
        tx_frame_t   f;
        int          k;
        if (byte_pos < 8)
            capture[byte_pos[2:0]] = b;
        if (byte_pos < 9)
            byte_pos = byte_pos + 4'd1;
        if (!e)
            return;
        if (byte_pos < 9)
        begin
            byte_pos = 4'd0;
            return;
        end
        byte_pos = 4'd0;
        if (capture[0] != HDR0 || capture[1] != HDR1)
            return;
        id = capture[2];
        word = {capture[6], capture[5], capture[4], capture[3]};
        if (byte_sum(id, word) != capture[7])
            return;
        if (id < TABLE_SIZE)
            param_mem[id[IDX_W-1:0]] = word;
        if (ack_idx < TABLE_SIZE)
            param_mem[ack_idx[IDX_W-1:0]] = ONE_FLOAT;
        f = make_frame(ack_idx, entry_at(ack_idx));
        f.gains = (id <= gain_limit);
        // only one command acts: reset, then read-all, then jump
        if (id == rst_id)
            f.rst_req = (entry_at(id) & MAG_MASK) != 0;
        else if (id == rdall_id)
        begin
            frames_due.push_back(f);
            bursts++;
            for (k = 0; k < TABLE_SIZE; k++)
            begin
                f = make_frame(k[7:0], param_mem[k[IDX_W-1:0]]);
                f.last = (k == TABLE_SIZE - 1);
                frames_due.push_back(f);
            end
            return;
        end
        else if (id == jmp_id)
            f.jmp_req = (entry_at(id) & MAG_MASK) != 0;
        f.last = 1'b1;
        frames_due.push_back(f);
    endtask

    task automatic check_frame();
        tx_frame_t want;
        checked++;
        if (frames_due.size() == 0)
        begin
            note_mismatch($sformatf("unexpected frame id %02h value %08h", tx_id, tx_value));
            return;
        end
        want = frames_due.pop_front();
        if (tx_id !== want.id)
            note_mismatch($sformatf("frame %0d tx_id %02h, wanted %02h",
                                    checked, tx_id, want.id));
        if (tx_value !== want.value)
            note_mismatch($sformatf("frame %0d tx_value %08h, wanted %08h",
                                    checked, tx_value, want.value));
        if (tx_sum !== want.sum)
            note_mismatch($sformatf("frame %0d tx_sum %02h, wanted %02h",
                                    checked, tx_sum, want.sum));
        if (reset_request !== want.rst_req)
            note_mismatch($sformatf("frame %0d reset_request %b, wanted %b",
                                    checked, reset_request, want.rst_req));
        if (jump_request !== want.jmp_req)
            note_mismatch($sformatf("frame %0d jump_request %b, wanted %b",
                                    checked, jump_request, want.jmp_req));
        if (gains_updated !== want.gains)
            note_mismatch($sformatf("frame %0d gains_updated %b, wanted %b",
                                    checked, gains_updated, want.gains));
        if (last_frame !== want.last)
            note_mismatch($sformatf("frame %0d last_frame %b, wanted %b",
                                    checked, last_frame, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_idx    = 8'd31;
            rst_id     = 8'd30;
            rdall_id   = 8'd29;
            jmp_id     = 8'd28;
            gain_limit = 8'd17;
            byte_pos   = '0;
            for (int i = 0; i < 8; i++)
                capture[i] = '0;
            for (int i = 0; i < TABLE_SIZE; i++)
                param_mem[i] = '0;
            frames_due.delete();
            errors  = 0;
            checked = 0;
            bursts  = 0;
            fail_count     <= 0;
            due_count      <= 0;
            frames_checked <= 0;
            bursts_seen    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACK_ENTRY:    ack_idx = cfg_data;
                    CFG_RESET_CMD:    rst_id = cfg_data;
                    CFG_READ_ALL_CMD: rdall_id = cfg_data;
                    CFG_JUMP_CMD:     jmp_id = cfg_data;
                    CFG_LAST_GAIN_ID: gain_limit = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_frame();
            if (in_valid && !in_stall)
                parse_rx_byte(rx_byte, frame_end);
            if (run_over && frames_due.size() != 0)
            begin
                note_mismatch($sformatf("%0d frames never arrived", frames_due.size()));
                frames_due.delete();
            end
            fail_count     <= errors;
            due_count      <= frames_due.size();
            frames_checked <= checked;
            bursts_seen    <= bursts;
        end
    end

endmodule

// ===== sim/tb_param_frame_parser_with_ack.sv =====
// testbench top for the parameter frame parser: drives byte words, config
// writes and receiver stalls; checking is done by pfp_frame_checker; uses pfp_pkg
`timescale 1ns / 1ps

module tb_param_frame_parser_with_ack;

    import pfp_pkg::*;

    localparam int HOLD_CYCLES  = 250;        // long receiver hold for back-pressure
    localparam int SETTLE_CYCLE = 10;         // quiet time after the last frame
    localparam int PHASE_BYTES  = 36;         // random byte words per config phase
    localparam int LIMIT_NS     = 2_000_000;  // run limit

    // kinds of frames the stimulus can build
    typedef enum {FR_GOOD, FR_SHORT, FR_LONG, FR_BAD_HDR, FR_BAD_SUM} frame_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte = '0;
    logic                 frame_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           tx_id;
    logic [31:0]          tx_value;
    logic [7:0]           tx_sum;
    logic                 reset_request;
    logic                 jump_request;
    logic                 gains_updated;
    logic                 last_frame;
    logic                 run_over = 1'b0;
    int                   fail_count;
    int                   due_count;
    int                   frames_checked;
    int                   bursts_seen;

    // stimulus-side copies of the registers, used only to aim ids at commands
    logic [7:0] ack_sel = 8'd31;
    logic [7:0] rst_sel = 8'd30;
    logic [7:0] rdall_sel = 8'd29;
    logic [7:0] jmp_sel = 8'd28;
    logic [7:0] gain_sel = 8'd17;

    // handshakes between the sender and the receiver process
    bit no_idle = 1'b0;   // both sides run without gaps
    bit hold_req = 1'b0;  // ask the receiver for a long hold
    bit hold_on = 1'b0;   // receiver is in its long hold

    int bytes_sent = 0;
    int frames_sent = 0;
    int settings = 1;

    always #2 clk = ~clk;

    param_frame_parser_with_ack i_dut (.*);

    pfp_frame_checker i_checker (.*);

    // run limit, reckoned well above the slowest passing run
    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d frames still due", due_count);
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, mostly short and a few long, none when no_idle is set
    initial
    begin
        int k, m, r;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                // long hold so the block backs up and stalls its input
                hold_req = 1'b0;
                hold_on = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on = 1'b0;
            end
            k = $urandom_range(1, 8);
            out_stall <= 1'b0;
            repeat (k) @(posedge clk);
            m = 0;
            if (!no_idle)
            begin
                r = $urandom_range(0, 19);
                if (r >= 5 && r < 19)
                    m = $urandom_range(1, 3);
                else if (r == 19)
                    m = $urandom_range(20, 60);
            end
            if (m > 0)
            begin
                out_stall <= 1'b1;
                repeat (m) @(posedge clk);
            end
        end
    end

    // offer one byte word after a random gap and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        int r;
        gap = 0;
        if (!no_idle)
        begin
            r = $urandom_range(0, 19);
            if (r >= 10 && r < 18)
                gap = $urandom_range(1, 3);
            else if (r >= 18)
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // valid stays high straight into the next word when there is no gap
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // build a frame around id and word, then break it as the kind asks
    task automatic send_frame(input frame_kind_t kind, input logic [7:0] id,
                              input logic [31:0] word);
        logic [7:0] fb [0:11];
        logic [7:0] flip;
        int         n;
        int         i;
        int         w;
        fb[0] = HDR0;
        fb[1] = HDR1;
        fb[2] = id;
        fb[3] = word[7:0];
        fb[4] = word[15:8];
        fb[5] = word[23:16];
        fb[6] = word[31:24];
        fb[7] = id + word[7:0] + word[15:8] + word[23:16] + word[31:24];
        // tail and trailing bytes are never checked by the block
        for (i = 8; i < 12; i++)
            fb[i] = 8'($urandom_range(0, 255));
        n = 9;
        flip = 8'($urandom_range(1, 255));
        case (kind)
            FR_SHORT:   n = $urandom_range(1, 8);
            FR_LONG:    n = $urandom_range(10, 12);
            FR_BAD_HDR:
            begin
                w = $urandom_range(0, 1);
                fb[w] = fb[w] ^ flip;
            end
            FR_BAD_SUM: fb[7] = fb[7] ^ flip;
            default: ;
        endcase
        for (i = 0; i < n; i++)
            send_byte(fb[i], i == n - 1);
        frames_sent++;
    endtask

    // drop valid, let every due frame come out, then wait out the settle time
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLE) @(posedge clk);
    endtask

    // write all five registers on consecutive edges while the block is idle
    task automatic set_config(input logic [7:0] a, input logic [7:0] rs,
                              input logic [7:0] ra, input logic [7:0] j,
                              input logic [7:0] g);
        ack_sel = a;
        rst_sel = rs;
        rdall_sel = ra;
        jmp_sel = j;
        gain_sel = g;
        cfg_we <= 1'b1;
        cfg_index <= CFG_ACK_ENTRY;
        cfg_data <= a;
        @(posedge clk);
        cfg_index <= CFG_RESET_CMD;
        cfg_data <= rs;
        @(posedge clk);
        cfg_index <= CFG_READ_ALL_CMD;
        cfg_data <= ra;
        @(posedge clk);
        cfg_index <= CFG_JUMP_CMD;
        cfg_data <= j;
        @(posedge clk);
        cfg_index <= CFG_LAST_GAIN_ID;
        cfg_data <= g;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // main stimulus
    initial
    begin
        int          p;
        int          r;
        int          first;
        int          i;
        int          n;
        frame_kind_t kind;
        logic [7:0]  fid;
        logic [31:0] fword;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < 5; p++)
        begin
            // register settings: reset values, all zero, all ones, ack out of
            // the table with read-all and jump on one id, then random
            case (p)
                1: set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: set_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                3: set_config(8'd40, 8'd2, 8'd7, 8'd7, 8'd31);
                4: set_config(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                              8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                              8'($urandom_range(0, 255)));
                default: ;
            endcase
            // one stretch with no idling on either side
            no_idle = (p == 1);

            if (p == 0)
            begin
                // directed: all-ones word at id 0, a short frame, a read-all
                send_frame(FR_GOOD, 8'd0, 32'hFFFF_FFFF);
                send_frame(FR_SHORT, 8'd5, 32'h1234_5678);
                send_frame(FR_GOOD, rdall_sel, 32'h0);
                wait_idle();

                // back-pressure: receiver holds while frames keep coming
                hold_req = 1'b1;
                while (!hold_on)
                    @(posedge clk);
                no_idle = 1'b1;
                send_frame(FR_GOOD, rdall_sel, $urandom);
                send_frame(FR_GOOD, rst_sel, 32'h8000_0000);
                send_frame(FR_GOOD, jmp_sel, 32'h0000_0001);
                no_idle = 1'b0;
            end

            // random part: mostly good frames aimed at commands and boundaries
            first = bytes_sent;
            while (bytes_sent - first < PHASE_BYTES)
            begin
                r = $urandom_range(0, 11);
                case (r)
                    0: fid = rst_sel;
                    1: fid = rdall_sel;
                    2: fid = jmp_sel;
                    3: fid = ack_sel;
                    4: fid = gain_sel;
                    5: fid = gain_sel + 8'd1;
                    6: fid = 8'd0;
                    7: fid = 8'(TABLE_SIZE - 1);
                    8: fid = 8'(TABLE_SIZE);
                    default: fid = 8'($urandom_range(0, 255));
                endcase
                // plus and minus zero, one, all ones and random words
                r = $urandom_range(0, 5);
                case (r)
                    0: fword = 32'h0;
                    1: fword = 32'h8000_0000;
                    2: fword = ONE_FLOAT;
                    3: fword = 32'hFFFF_FFFF;
                    default: fword = $urandom;
                endcase
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    // noise: random bytes, usually closed by an end mark
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        send_byte(8'($urandom_range(0, 255)),
                                  (i == n - 1) ? ($urandom_range(0, 3) != 0)
                                               : ($urandom_range(0, 5) == 0));
                end
                else
                begin
                    if (r < 70)
                        kind = FR_GOOD;
                    else if (r < 78)
                        kind = FR_SHORT;
                    else if (r < 85)
                        kind = FR_LONG;
                    else if (r < 92)
                        kind = FR_BAD_HDR;
                    else
                        kind = FR_BAD_SUM;
                    send_frame(kind, fid, fword);
                end
            end
            wait_idle();
        end

        $display("run covered %0d byte words in %0d frames over %0d register settings",
                 bytes_sent, frames_sent, settings);
        $display("%0d outgoing frames compared, %0d read-all bursts among them",
                 frames_checked, bursts_seen);

        // let the checker flag anything still due, then read its count
        run_over <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== param_frame_parser_with_ack.f =====
hdl/pfp_pkg.sv
hdl/pfp_ctrl.sv
hdl/pfp_datapath.sv
hdl/param_frame_parser_with_ack.sv
sim/pfp_frame_checker.sv
sim/tb_param_frame_parser_with_ack.sv
